>>> rtl/fsuc_pkg.sv
// ----------------------------------------------------------------------------
// fsuc_pkg
// Types, widths, unit tables and divider step function shared by the
// forecast step unit converter.
// ----------------------------------------------------------------------------
`default_nettype none

package fsuc_pkg;

  // table sizes
  localparam int NCODED = 14;
  localparam int NSTEP  = 16;

  // widths
  localparam int TAB_W      = 23;  // signed seconds-per-unit entry
  localparam int DIVS_W     = 22;  // divisor magnitude
  localparam int PROD_W     = 55;  // signed step times seconds
  localparam int MAG_W      = 54;  // product magnitude
  localparam int SUM_W      = 58;  // signed range arithmetic
  localparam int DIV_BITS   = 6;   // quotient bits per divider stage
  localparam int DIV_STAGES = MAG_W / DIV_BITS;

  localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK,
    ST_DECODE,
    ST_RANGE
  } status_t;

  // divider partial state
  typedef struct packed {
    logic [DIVS_W-1:0] rem;
    logic [MAG_W-1:0]  nq;
  } div_st_t;

  // item fields carried alongside the divider
  typedef struct packed {
    logic                     func;
    logic signed [31:0]       new_step;
    logic signed [31:0]       coded_step;
    logic [7:0]               coded_units;
    logic [7:0]               step_units;
    logic                     range_present;
    logic [7:0]               range_unit;
    logic [31:0]              range_length;
    logic                     rng_err;
    logic                     cc_one;
    logic                     ss_one;
    logic                     cc_neg;
    logic                     ss_neg;
    logic                     cr_neg;
    logic signed [PROD_W-1:0] v;
    logic                     s_neg;
  } meta_t;

  // resolved word before the range update
  typedef struct packed {
    status_t                  status;
    logic                     func;
    logic signed [SUM_W-1:0]  val;
    logic signed [SUM_W-1:0]  ncoded;
    logic signed [SUM_W-1:0]  old;
    logic signed [SUM_W-1:0]  qc;
    logic                     same_ru;
    logic [7:0]               ncu;
    logic [7:0]               fs;
    logic signed [31:0]       coded_step;
    logic [7:0]               coded_units;
    logic [7:0]               step_units;
    logic                     range_present;
    logic [31:0]              range_length;
  } res_t;

  // seconds per coded unit
  function automatic logic signed [TAB_W-1:0] coded_secs(input logic [7:0] idx);
    logic signed [TAB_W-1:0] r;
    case (idx) inside
      8'd0:          r = TAB_W'(60);
      8'd1:          r = TAB_W'(3600);
      8'd2:          r = TAB_W'(86400);
      8'd3:          r = TAB_W'(2592000);
      [8'd4:8'd9]:   r = TAB_W'(-1);
      8'd10:         r = TAB_W'(10800);
      8'd11:         r = TAB_W'(21600);
      8'd12:         r = TAB_W'(43200);
      default:       r = TAB_W'(1);
    endcase
    return r;
  endfunction

  // seconds per step unit
  function automatic logic signed [TAB_W-1:0] step_secs(input logic [7:0] idx);
    logic signed [TAB_W-1:0] r;
    case (idx)
      8'd14:   r = TAB_W'(900);
      8'd15:   r = TAB_W'(1800);
      default: r = coded_secs(idx);
    endcase
    return r;
  endfunction

  // magnitude of a table entry
  function automatic logic [DIVS_W-1:0] tab_mag(input logic signed [TAB_W-1:0] x);
    logic signed [TAB_W-1:0] a;
    a = x[TAB_W-1] ? -x : x;
    return a[DIVS_W-1:0];
  endfunction

  // a few restoring division steps
  function automatic div_st_t div_steps(input div_st_t st, input logic [DIVS_W-1:0] d);
    div_st_t       r;
    logic [DIVS_W:0] t;
    logic          ge;
    r = st;
    for (int i = 0; i < DIV_BITS; i++) begin
      t     = {r.rem, r.nq[MAG_W-1]};
      ge    = (t >= {1'b0, d});
      r.nq  = {r.nq[MAG_W-2:0], ge};
      r.rem = ge ? DIVS_W'(t - {1'b0, d}) : t[DIVS_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/forecast_step_unit_converter_core.sv
// ----------------------------------------------------------------------------
// forecast_step_unit_converter_core
// Converts a forecast step between coded and display units, with exactness
// fallback, and adjusts an optional time range length.
//
//   channel | ports                     | handshake
//   --------+---------------------------+-------------------------------
//   input   | in_*                      | start high, busy low
//   result  | out_*                     | out_valid strobe, one cycle
//
// One word enters every cycle; each result passes through the multiply
// and magnitude stages, the 9-stage constant divider, and the resolve,
// range-delta and output stages.
// busy is always low: the pipeline never stalls and the receiver cannot
// hold results off. rst_n (synchronous) clears only the valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module forecast_step_unit_converter_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_func,
  input  wire logic signed [31:0] in_new_step,
  input  wire logic signed [31:0] in_coded_step,
  input  wire logic [7:0]         in_coded_units,
  input  wire logic [7:0]         in_step_units,
  input  wire logic               in_range_present,
  input  wire logic [7:0]         in_range_unit,
  input  wire logic [31:0]        in_range_length,
  output logic                    out_valid,
  output logic signed [63:0]      out_step_value,
  output logic signed [63:0]      out_coded_step_out,
  output logic [7:0]              out_coded_units_out,
  output logic [7:0]              out_step_units_out,
  output logic [31:0]             out_range_length_out,
  output logic [1:0]              out_status
);

  localparam int NS     = fsuc_pkg::DIV_STAGES;
  localparam int PROD_W = fsuc_pkg::PROD_W;
  localparam int MAG_W  = fsuc_pkg::MAG_W;
  localparam int DIVS_W = fsuc_pkg::DIVS_W;
  localparam int SUM_W  = fsuc_pkg::SUM_W;
  localparam int TAB_W  = fsuc_pkg::TAB_W;

  assign busy = 1'b0;

  // ---------------- stage 1: table lookup and products ----------------
  logic signed [TAB_W-1:0]  cc, ss, cr;
  logic signed [PROD_W-1:0] s1_s_nxt;
  fsuc_pkg::meta_t          s1_m_nxt;

  logic                     s1_vld_r;
  fsuc_pkg::meta_t          s1_m_r;
  logic signed [PROD_W-1:0] s1_s_r;
  logic [DIVS_W-1:0]        s1_dss_r, s1_dcc_r, s1_dcr_r;

  always_comb begin
    cc = fsuc_pkg::coded_secs(in_coded_units);
    ss = fsuc_pkg::step_secs(in_step_units);
    cr = fsuc_pkg::coded_secs(in_range_unit);
    s1_m_nxt.func          = in_func;
    s1_m_nxt.new_step      = in_new_step;
    s1_m_nxt.coded_step    = in_coded_step;
    s1_m_nxt.coded_units   = in_coded_units;
    s1_m_nxt.step_units    = in_step_units;
    s1_m_nxt.range_present = in_range_present;
    s1_m_nxt.range_unit    = in_range_unit;
    s1_m_nxt.range_length  = in_range_length;
    s1_m_nxt.rng_err       = (in_coded_units != in_step_units) &&
                             ((in_coded_units >= 8'(fsuc_pkg::NCODED)) ||
                              (in_step_units >= 8'(fsuc_pkg::NSTEP)));
    s1_m_nxt.cc_one        = (fsuc_pkg::tab_mag(cc) == DIVS_W'(1));
    s1_m_nxt.ss_one        = (fsuc_pkg::tab_mag(ss) == DIVS_W'(1));
    s1_m_nxt.cc_neg        = cc[TAB_W-1];
    s1_m_nxt.ss_neg        = ss[TAB_W-1];
    s1_m_nxt.cr_neg        = cr[TAB_W-1];
    s1_m_nxt.v             = PROD_W'(in_coded_step) * PROD_W'(cc);
    s1_m_nxt.s_neg         = 1'b0;
    s1_s_nxt               = PROD_W'(in_new_step) * PROD_W'(ss);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_m_r   <= s1_m_nxt;
    s1_s_r   <= s1_s_nxt;
    s1_dss_r <= fsuc_pkg::tab_mag(ss);
    s1_dcc_r <= fsuc_pkg::tab_mag(cc);
    s1_dcr_r <= fsuc_pkg::tab_mag(cr);
  end

  // ---------------- stage 2: magnitudes for the dividers ----------------
  logic                     s2_vld_r;
  fsuc_pkg::meta_t          s2_m_r;
  logic [MAG_W-1:0]         s2_vmag_r, s2_smag_r;
  logic [DIVS_W-1:0]        s2_dss_r, s2_dcc_r, s2_dcr_r;
  logic signed [PROD_W-1:0] vabs, sabs;
  fsuc_pkg::meta_t          s2_m_nxt;

  always_comb begin
    vabs           = s1_m_r.v[PROD_W-1] ? -s1_m_r.v : s1_m_r.v;
    sabs           = s1_s_r[PROD_W-1] ? -s1_s_r : s1_s_r;
    s2_m_nxt       = s1_m_r;
    s2_m_nxt.s_neg = s1_s_r[PROD_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_m_r    <= s2_m_nxt;
    s2_vmag_r <= vabs[MAG_W-1:0];
    s2_smag_r <= sabs[MAG_W-1:0];
    s2_dss_r  <= s1_dss_r;
    s2_dcc_r  <= s1_dcc_r;
    s2_dcr_r  <= s1_dcr_r;
  end

  // ---------------- constant dividers ----------------
  logic [MAG_W-1:0] qa, qb, qc;
  logic             nza, nzb, nzc;

  // read: v over step-unit seconds
  fsuc_div u_div_read (
    .clk      (clk),
    .dividend (s2_vmag_r),
    .divisor  (s2_dss_r),
    .quotient (qa),
    .rem_nz   (nza)
  );

  // write: s over coded-unit seconds
  fsuc_div u_div_write (
    .clk      (clk),
    .dividend (s2_smag_r),
    .divisor  (s2_dcc_r),
    .quotient (qb),
    .rem_nz   (nzb)
  );

  // range: s over range-unit seconds
  fsuc_div u_div_range (
    .clk      (clk),
    .dividend (s2_smag_r),
    .divisor  (s2_dcr_r),
    .quotient (qc),
    .rem_nz   (nzc)
  );

  // side fields travel next to the divider
  fsuc_pkg::meta_t dly_m_r   [NS];
  logic [NS-1:0]   dly_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_vld_r <= '0;
    end else begin
      dly_vld_r <= {dly_vld_r[NS-2:0], s2_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    dly_m_r[0] <= s2_m_r;
    for (int k = 1; k < NS; k++) begin
      dly_m_r[k] <= dly_m_r[k-1];
    end
  end

  // ---------------- stage 3: resolve read and write ----------------
  fsuc_pkg::meta_t         m;
  fsuc_pkg::res_t          r3_nxt;
  logic signed [SUM_W-1:0] qa_s, qb_s, qc_s, cs_x, ns_x, v_x;
  logic                    eq_u, read_err, wr_rng;
  logic                    s3_vld_r;
  fsuc_pkg::res_t          s3_r;

  always_comb begin
    m    = dly_m_r[NS-1];
    qa_s = SUM_W'(signed'({1'b0, qa}));
    qb_s = SUM_W'(signed'({1'b0, qb}));
    qc_s = SUM_W'(signed'({1'b0, qc}));
    if (m.v[PROD_W-1] ^ m.ss_neg) qa_s = -qa_s;
    if (m.s_neg ^ m.cc_neg)       qb_s = -qb_s;
    if (m.s_neg ^ m.cr_neg)       qc_s = -qc_s;
    cs_x     = SUM_W'(m.coded_step);
    ns_x     = SUM_W'(m.new_step);
    v_x      = SUM_W'(m.v);
    eq_u     = (m.coded_units == m.step_units);
    read_err = !eq_u && m.v[PROD_W-1] && (m.cc_one || m.ss_one);

    // read result and step-unit fallback
    r3_nxt.val = (eq_u || nza) ? cs_x : qa_s;
    r3_nxt.fs  = (!eq_u && !read_err && nza) ? m.coded_units : m.step_units;
    if (eq_u) begin
      r3_nxt.old = cs_x;
    end else if (read_err) begin
      r3_nxt.old = v_x;
    end else begin
      r3_nxt.old = nza ? cs_x : qa_s;
    end

    // write result and coded-unit fallback
    if (!eq_u && nzb) begin
      r3_nxt.ncu    = m.step_units;
      r3_nxt.ncoded = ns_x;
    end else if (!eq_u) begin
      r3_nxt.ncu    = m.coded_units;
      r3_nxt.ncoded = qb_s;
    end else begin
      r3_nxt.ncu    = m.coded_units;
      r3_nxt.ncoded = ns_x;
    end
    r3_nxt.same_ru = (r3_nxt.ncu == m.range_unit);
    wr_rng = m.range_present && !r3_nxt.same_ru &&
             ((r3_nxt.ncu >= 8'(fsuc_pkg::NCODED)) ||
              (m.range_unit >= 8'(fsuc_pkg::NCODED)));

    // status
    if (m.rng_err) begin
      r3_nxt.status = fsuc_pkg::ST_RANGE;
    end else if (!m.func) begin
      r3_nxt.status = read_err ? fsuc_pkg::ST_DECODE : fsuc_pkg::ST_OK;
    end else begin
      r3_nxt.status = wr_rng ? fsuc_pkg::ST_RANGE : fsuc_pkg::ST_OK;
    end

    r3_nxt.func          = m.func;
    r3_nxt.qc            = qc_s;
    r3_nxt.coded_step    = m.coded_step;
    r3_nxt.coded_units   = m.coded_units;
    r3_nxt.step_units    = m.step_units;
    r3_nxt.range_present = m.range_present;
    r3_nxt.range_length  = m.range_length;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= dly_vld_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    s3_r <= r3_nxt;
  end

  // ---------------- stage 4: range delta ----------------
  logic                    s4_vld_r;
  fsuc_pkg::res_t          s4_r;
  logic signed [SUM_W-1:0] s4_delta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s4_r       <= s3_r;
    s4_delta_r <= s3_r.same_ru ? (s3_r.ncoded - s3_r.old) : s3_r.qc;
  end

  // ---------------- output stage: clamp and select ----------------
  logic signed [SUM_W-1:0] len_new;
  logic [31:0]             len_clamp;
  logic signed [63:0]      step_nxt, coded_nxt;
  logic [7:0]              cuo_nxt, suo_nxt;
  logic [31:0]             len_nxt;

  always_comb begin
    len_new = SUM_W'(signed'({1'b0, s4_r.range_length})) - s4_delta_r;
    if (len_new[SUM_W-1]) begin
      len_clamp = '0;
    end else if (|len_new[SUM_W-2:32]) begin
      len_clamp = fsuc_pkg::LEN_MAX;
    end else begin
      len_clamp = len_new[31:0];
    end

    step_nxt  = '0;
    coded_nxt = 64'(s4_r.coded_step);
    cuo_nxt   = s4_r.coded_units;
    suo_nxt   = s4_r.step_units;
    len_nxt   = s4_r.range_length;
    if (s4_r.status == fsuc_pkg::ST_OK) begin
      suo_nxt = s4_r.fs;
      if (!s4_r.func) begin
        step_nxt = 64'(s4_r.val);
      end else begin
        coded_nxt = 64'(s4_r.ncoded);
        cuo_nxt   = s4_r.ncu;
        if (s4_r.range_present) len_nxt = len_clamp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_step_value       <= step_nxt;
    out_coded_step_out   <= coded_nxt;
    out_coded_units_out  <= cuo_nxt;
    out_step_units_out   <= suo_nxt;
    out_range_length_out <= len_nxt;
    out_status           <= s4_r.status;
  end

  // unused remainder flag of the range divider
  logic unused_nzc;
  assign unused_nzc = nzc;

endmodule

`default_nettype wire

>>> rtl/fsuc_div.sv
// ----------------------------------------------------------------------------
// fsuc_div
// Pipelined unsigned divider, a few quotient bits per stage, giving the
// quotient and whether the remainder is nonzero.
// ----------------------------------------------------------------------------
`default_nettype none

module fsuc_div (
  input  wire logic                            clk,
  input  wire logic [fsuc_pkg::MAG_W-1:0]      dividend,
  input  wire logic [fsuc_pkg::DIVS_W-1:0]     divisor,
  output logic      [fsuc_pkg::MAG_W-1:0]      quotient,
  output logic                                 rem_nz
);

  localparam int NS = fsuc_pkg::DIV_STAGES;

  fsuc_pkg::div_st_t               st_r   [NS];
  fsuc_pkg::div_st_t               st_nxt [NS];
  logic [fsuc_pkg::DIVS_W-1:0]     d_r    [NS];
  logic [fsuc_pkg::DIVS_W-1:0]     d_nxt  [NS];

  // stage step logic
  always_comb begin
    fsuc_pkg::div_st_t st0;
    st0.rem   = '0;
    st0.nq    = dividend;
    st_nxt[0] = fsuc_pkg::div_steps(st0, divisor);
    d_nxt[0]  = divisor;
    for (int k = 1; k < NS; k++) begin
      st_nxt[k] = fsuc_pkg::div_steps(st_r[k-1], d_r[k-1]);
      d_nxt[k]  = d_r[k-1];
    end
  end

  // stage registers
  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      st_r[k] <= st_nxt[k];
      d_r[k]  <= d_nxt[k];
    end
  end

  assign quotient = st_r[NS-1].nq;
  assign rem_nz   = |st_r[NS-1].rem;

endmodule

`default_nettype wire
